/* hw/rtl/fmmt_pkg.sv */
// fmmt_pkg: shared types and constants of the fingerprint match table
// depends on nothing

package fmmt_pkg;

    localparam int FEAT_W = 20;   // width of one feature reading
    localparam int TOL_W  = 19;   // width of one tolerance register
    localparam int NFEAT  = 4;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;
    localparam int DIST_W = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [STAT_W-1:0] STAT_MATCH = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NEW   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IRR_TOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TOL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TOL = 2'd3;

    localparam logic [TOL_W-1:0] IRR_TOL_RST   = 19'd768;
    localparam logic [TOL_W-1:0] DC_TOL_RST    = 19'd768;
    localparam logic [TOL_W-1:0] GAIN_TOL_RST  = 19'd1311;
    localparam logic [TOL_W-1:0] PHASE_TOL_RST = 19'd512;

    localparam int FEAT_IRR   = 0;
    localparam int FEAT_DC    = 1;
    localparam int FEAT_GAIN  = 2;
    localparam int FEAT_PHASE = 3;

    localparam logic [6:0] GAIN_SCALE = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_MWAIT,
        ST_LOAD,
        ST_MED,
        ST_SCORE,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef logic signed [FEAT_W-1:0] feat_t;

    function automatic logic [FEAT_W:0] abs_diff(input feat_t a, input feat_t b);
        logic signed [FEAT_W:0] d;
        d = $signed({a[FEAT_W-1], a}) - $signed({b[FEAT_W-1], b});
        abs_diff = d[FEAT_W] ? (~d + 1'b1) : d;
    endfunction

endpackage

/* hw/rtl/fmmt_ram.sv */
// fmmt_ram: generic single-port-write, single-port-read ram, registered read
// depends on nothing

module fmmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fingerprint_median_match_table_top.sv */
// fingerprint_median_match_table_top: radio fingerprint matcher over a device table
// depends on fmmt_pkg and fmmt_ram
//
//  channel   dir  payload                                     request when
//  s_axis    in   4 x 20-bit signed features                  tvalid & tready
//  m_axis    out  device slot (tdata), status (tuser)         tvalid & tready
//  cfg       in   tolerance register write                    cfg_wr_en
//
// during a scan the history ram gives one reading per cycle to the four insertion sorters.
// aresetn clears the device count and loads the default tolerances; ram contents need no clearing.
// a new request is taken while the previous result waits on m_axis.

module fingerprint_median_match_table_top #(
    parameter int MAX_DEVICES = 64,
    parameter int WINDOW      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // image_rejection, dc_level, gain_error, phase_error
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // device_slot, zero pad
    output logic [7:0]  m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_wr_en,
    input  logic [fmmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fmmt_pkg::TOL_W-1:0]     cfg_wdata
);

    import fmmt_pkg::*;

    localparam int IW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW    = $clog2(MAX_DEVICES + 1);
    localparam int HDEP  = MAX_DEVICES * WINDOW;
    localparam int AW    = (HDEP > 1) ? $clog2(HDEP) : 1;
    localparam int HDEPR = (HDEP > 1) ? HDEP : 2;
    localparam int MDEPR = (MAX_DEVICES > 1) ? MAX_DEVICES : 2;
    localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int HW    = NFEAT * FEAT_W;
    localparam int MW    = FW + PW;

    state_t state_reg, state_next;

    logic [TOL_W-1:0] tol_reg [NFEAT];
    feat_t            x_reg [NFEAT];
    feat_t            buf_reg [NFEAT][WINDOW];
    feat_t            med_reg [NFEAT];

    logic [CW-1:0] count_reg;
    logic [IW-1:0] dev_reg;
    logic [FW-1:0] n_reg, iss_reg, k_reg;
    logic [PW-1:0] ptr_reg;
    logic          rd_pend_reg;

    logic              found_reg;
    logic [IW-1:0]     best_reg;
    logic [DIST_W-1:0] best_score_reg;
    logic [FW-1:0]     best_fill_reg;
    logic [PW-1:0]     best_ptr_reg;

    logic              m_valid_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [STAT_W-1:0] res_stat_reg;

    // memories
    logic          h_wr_en;
    logic [AW-1:0] h_wr_addr, h_rd_addr;
    logic [HW-1:0] h_wr_data, h_rd_data;
    logic          m_wr_en;
    logic [IW-1:0] m_wr_addr;
    logic [MW-1:0] m_wr_data, m_rd_data;

    fmmt_ram #(.WIDTH(HW), .DEPTH(HDEPR)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    fmmt_ram #(.WIDTH(MW), .DEPTH(MDEPR)) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (m_wr_en),
        .wr_addr (m_wr_addr),
        .wr_data (m_wr_data),
        .rd_addr (dev_reg),
        .rd_data (m_rd_data)
    );

    logic accept_in;
    logic last_dev;
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign last_dev = ({1'b0, {(CW-IW){1'b0}}, dev_reg} + 1'b1) == {1'b0, count_reg};

    assign h_rd_addr = AW'(dev_reg) * AW'(WINDOW) + AW'(iss_reg);

    // insertion of one reading per feature into the sorted buffers
    feat_t ins_next [NFEAT][WINDOW];
    logic  gt [NFEAT][WINDOW];
    always_comb begin
        for (int f = 0; f < NFEAT; f++) begin
            for (int j = 0; j < WINDOW; j++) begin
                gt[f][j] = (FW'(j) < k_reg) &&
                           (buf_reg[f][j] > $signed(h_rd_data[f*FEAT_W +: FEAT_W]));
            end
            for (int j = 0; j < WINDOW; j++) begin
                if ((FW'(j) < k_reg) && !gt[f][j]) begin
                    ins_next[f][j] = buf_reg[f][j];
                end else if (j > 0 && gt[f][(j > 0) ? j-1 : 0]) begin
                    ins_next[f][j] = buf_reg[f][(j > 0) ? j-1 : 0];
                end else begin
                    ins_next[f][j] = $signed(h_rd_data[f*FEAT_W +: FEAT_W]);
                end
            end
        end
    end

    // median of the sorted window
    logic [FW-1:0] half_n, half_m1;
    feat_t         med_val [NFEAT];
    always_comb begin
        logic signed [FEAT_W:0] s;
        half_n  = n_reg >> 1;
        half_m1 = half_n - 1'b1;
        for (int f = 0; f < NFEAT; f++) begin
            s = $signed({buf_reg[f][half_n[PW-1:0]][FEAT_W-1], buf_reg[f][half_n[PW-1:0]]})
              + $signed({buf_reg[f][half_m1[PW-1:0]][FEAT_W-1],
                         buf_reg[f][half_m1[PW-1:0]]});
            if (n_reg[0]) begin
                med_val[f] = buf_reg[f][half_n[PW-1:0]];
            end else begin
                med_val[f] = s[FEAT_W:1];
            end
        end
    end

    // scoring
    logic [FEAT_W:0]   dif [NFEAT];
    logic              qual;
    logic [27:0]       gain_prod;
    logic [DIST_W-1:0] score;
    logic              better;
    always_comb begin
        qual = 1'b1;
        for (int f = 0; f < NFEAT; f++) begin
            dif[f] = abs_diff(x_reg[f], med_reg[f]);
            if (dif[f] > {2'b00, tol_reg[f]}) begin
                qual = 1'b0;
            end
        end
        gain_prod = 28'(dif[FEAT_GAIN]) * 28'(GAIN_SCALE);
        score = DIST_W'(dif[FEAT_IRR]) + DIST_W'(dif[FEAT_DC])
              + DIST_W'(gain_prod[27:8]) + DIST_W'(dif[FEAT_PHASE]);
        better = qual && (!found_reg || score < best_score_reg);
    end

    // write-back of the reading at decision time
    logic [IW-1:0]   wb_dev;
    logic [PW-1:0]   wb_ptr, wb_ptr_next;
    logic [FW-1:0]   wb_fill, wb_fill_next;
    logic            room;
    logic [IW+SLOT_W-1:0] slot_ext;
    always_comb begin
        room = count_reg < CW'(MAX_DEVICES);
        if (found_reg) begin
            wb_dev  = best_reg;
            wb_ptr  = best_ptr_reg;
            wb_fill = best_fill_reg;
        end else begin
            wb_dev  = IW'(count_reg);
            wb_ptr  = '0;
            wb_fill = '0;
        end
        wb_ptr_next  = ((FW+1)'(wb_ptr) + 1'b1 == (FW+1)'(WINDOW)) ? '0 : PW'(wb_ptr + 1'b1);
        wb_fill_next = (wb_fill < FW'(WINDOW)) ? FW'(wb_fill + 1'b1) : wb_fill;
        slot_ext     = {{SLOT_W{1'b0}}, wb_dev};
        h_wr_en   = (state_reg == ST_DECIDE) && (found_reg || room);
        h_wr_addr = AW'(wb_dev) * AW'(WINDOW) + AW'(wb_ptr);
        for (int f = 0; f < NFEAT; f++) begin
            h_wr_data[f*FEAT_W +: FEAT_W] = x_reg[f];
        end
        m_wr_en   = h_wr_en;
        m_wr_addr = wb_dev;
        m_wr_data = {wb_ptr_next, wb_fill_next};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_META;
                end
            end
            ST_META:  state_next = ST_MWAIT;
            ST_MWAIT: state_next = ST_LOAD;
            ST_LOAD: begin
                if (k_reg == n_reg) begin
                    state_next = ST_MED;
                end
            end
            ST_MED:   state_next = ST_SCORE;
            ST_SCORE: state_next = last_dev ? ST_DECIDE : ST_META;
            ST_DECIDE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            tol_reg[FEAT_IRR]   <= IRR_TOL_RST;
            tol_reg[FEAT_DC]    <= DC_TOL_RST;
            tol_reg[FEAT_GAIN]  <= GAIN_TOL_RST;
            tol_reg[FEAT_PHASE] <= PHASE_TOL_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IRR_TOL:   tol_reg[FEAT_IRR]   <= cfg_wdata;
                    CFG_DC_TOL:    tol_reg[FEAT_DC]    <= cfg_wdata;
                    CFG_GAIN_TOL:  tol_reg[FEAT_GAIN]  <= cfg_wdata;
                    CFG_PHASE_TOL: tol_reg[FEAT_PHASE] <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_pend_reg <= (state_reg == ST_LOAD) && (iss_reg < n_reg);
            if (state_reg == ST_DECIDE && !found_reg && room) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            for (int f = 0; f < NFEAT; f++) begin
                x_reg[f] <= $signed(s_axis_tdata[f*FEAT_W +: FEAT_W]);
            end
            dev_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (state_reg == ST_MWAIT) begin
            n_reg   <= m_rd_data[FW-1:0];
            ptr_reg <= m_rd_data[MW-1:FW];
            iss_reg <= '0;
            k_reg   <= '0;
        end
        if (state_reg == ST_LOAD && iss_reg < n_reg) begin
            iss_reg <= iss_reg + 1'b1;
        end
        if (rd_pend_reg) begin
            buf_reg <= ins_next;
            k_reg   <= k_reg + 1'b1;
        end
        if (state_reg == ST_MED) begin
            med_reg <= med_val;
        end
        if (state_reg == ST_SCORE) begin
            if (better && n_reg != '0) begin
                found_reg      <= 1'b1;
                best_reg       <= dev_reg;
                best_score_reg <= score;
                best_fill_reg  <= n_reg;
                best_ptr_reg   <= ptr_reg;
            end
            dev_reg <= dev_reg + 1'b1;
        end
        if (state_reg == ST_DECIDE) begin
            if (found_reg) begin
                res_slot_reg <= slot_ext[SLOT_W-1:0];
                res_stat_reg <= STAT_MATCH;
            end else if (room) begin
                res_slot_reg <= slot_ext[SLOT_W-1:0];
                res_stat_reg <= STAT_NEW;
            end else begin
                res_slot_reg <= '0;
                res_stat_reg <= STAT_FULL;
            end
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready)) begin
            m_slot_reg <= res_slot_reg;
            m_stat_reg <= res_stat_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(8-SLOT_W){1'b0}}, m_slot_reg};
    assign m_axis_tuser  = m_stat_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_DEVICES))
        else $error("device count above table size");

    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == STAT_FULL) |-> (m_axis_tdata == '0))
        else $error("table full result carries a nonzero slot");

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (k_reg <= n_reg && iss_reg <= n_reg))
        else $error("window load ran past fill count");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in |=> (state_reg != ST_IDLE))
        else $error("request accepted without starting a scan");

    a_grow_on_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && !found_reg && room) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("new device not counted");

endmodule
